[rtl/krd_pkg.sv]
`default_nettype none

package krd_pkg;

  // Ring size and the widths that follow from it.
  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int OP_W    = 3;
  localparam int ST_W    = 2;
  localparam int ENTRY_W = 5;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;
  localparam logic [OP_W-1:0] OP_UPDATE     = 3'd5;
  localparam logic [OP_W-1:0] OP_MAX        = 3'd6;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_MISS = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [KEY_W-1:0] key;
  } record_t;

  // Per-cell control: load from the item, take from the next cell (shift
  // toward the front), or take from the previous cell (shift toward the back).
  typedef struct packed {
    logic load;
    logic shl;
    logic shr;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/krd_cell.sv]
`default_nettype none

module krd_cell
  import krd_pkg::*;
(
  input  wire logic       clk,
  input  wire cell_ctrl_t ctrl,
  input  wire record_t    next_rec,
  input  wire record_t    prev_rec,
  input  wire record_t    load_rec,
  output record_t         rec_q
);

  record_t rec_r;

  // One record slot; it loads, or takes a neighbor's record, or holds.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rec_r <= load_rec;
    end else if (ctrl.shl) begin
      rec_r <= next_rec;
    end else if (ctrl.shr) begin
      rec_r <= prev_rec;
    end
  end

  assign rec_q = rec_r;

endmodule

`default_nettype wire

[rtl/keyed_record_deque_top.sv]
`default_nettype none

// Bounded double-ended queue of (key, value) records held in a row of DEPTH
// record cells in queue order, the front record in cell 0. Push and pop
// transactions and the unused opcode register their result at the end of
// the accept cycle, and a new item may be accepted in every cycle while the
// output side keeps up. Search, update and max rotate the whole row once
// past cell 0, where the key compare and the running maximum sit, and
// register their result when the rotation ends; the last rotation step waits
// for the output register to be free. Input items are accepted only while no
// scan is running and the output register is free or being taken.
module keyed_record_deque_top
  import krd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // item_key[31:0], item_value[63:32]
  input  wire logic [2:0]  in_tuser,   // opcode[2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // found_key[31:0], found_value[63:32],
                                       // entry_count[68:64], zero fill above
  output logic [1:0]       out_tuser   // status[1:0]
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;
  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(DEPTH - 1);

  logic             state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [OP_W-1:0]  scan_op_r, scan_op_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic             found_r, found_nxt;
  record_t          best_r, best_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]  out_status_r, out_status_nxt;
  record_t          out_rec_r, out_rec_nxt;
  logic [CNT_W-1:0] out_count_r, out_count_nxt;

  record_t    cell_q [DEPTH];
  cell_ctrl_t ctrl [DEPTH];
  record_t    item_rec;
  record_t    wrap_rec;
  logic       out_free;
  logic       accept;
  logic       push_back_en;
  logic       shl_en;
  logic       shr_en;
  logic       head_valid;
  logic       key_hit;
  logic       max_take;
  logic       step;

  // The record carried by the input transaction: key in the low half.
  assign item_rec = record_t'(in_tdata[KEY_W+VAL_W-1:0]);

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;
  assign step      = (state_r == S_SCAN) && ((pos_r != LAST_POS) || out_free);

  // Compare logic at the head cell during a scan.
  assign head_valid = ({1'b0, pos_r} < count_r);
  assign key_hit    = head_valid && !found_r && (cell_q[0].key == key_r);
  assign max_take   = head_valid &&
                      ((!found_r && !cell_q[0].value[VAL_W-1]) ||
                       (found_r && ($signed(cell_q[0].value) > $signed(best_r.value))));

  // The record leaving cell 0 re-enters at the back, with a new value on an update hit.
  always_comb begin
    wrap_rec = cell_q[0];
    if ((scan_op_r == OP_UPDATE) && key_hit) begin
      wrap_rec.value = val_r;
    end
  end

  // Operation sequencing and the result register.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    scan_op_nxt    = scan_op_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    found_nxt      = found_r;
    best_nxt       = best_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_rec_nxt    = out_rec_r;
    out_count_nxt  = out_count_r;
    push_back_en   = 1'b0;
    shl_en         = 1'b0;
    shr_en         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_status_nxt = ST_OK;
          out_rec_nxt    = '0;
          case (in_tuser)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
              if (count_r == CNT_W'(DEPTH)) begin
                out_status_nxt = ST_FULL;
              end else begin
                push_back_en = (in_tuser == OP_PUSH_BACK);
                shr_en       = (in_tuser == OP_PUSH_FRONT);
                count_nxt    = count_r + 1'b1;
              end
              out_valid_nxt = 1'b1;
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (count_r == '0) begin
                out_status_nxt = ST_MISS;
              end else begin
                shl_en    = (in_tuser == OP_POP_FRONT);
                count_nxt = count_r - 1'b1;
              end
              out_valid_nxt = 1'b1;
            end
            OP_SEARCH, OP_UPDATE, OP_MAX: begin
              state_nxt   = S_SCAN;
              scan_op_nxt = in_tuser;
              key_nxt     = item_rec.key;
              val_nxt     = item_rec.value;
              pos_nxt     = '0;
              found_nxt   = 1'b0;
              best_nxt    = '0;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
          out_count_nxt = count_nxt;
        end
      end
      S_SCAN: begin
        if (step) begin
          shl_en  = 1'b1;
          pos_nxt = pos_r + 1'b1;
          if ((scan_op_r == OP_MAX) ? max_take : key_hit) begin
            found_nxt = 1'b1;
            best_nxt  = cell_q[0];
          end
          if (pos_r == LAST_POS) begin
            state_nxt      = S_IDLE;
            out_valid_nxt  = 1'b1;
            out_status_nxt = found_nxt ? ST_OK : ST_MISS;
            out_rec_nxt    = (found_nxt && (scan_op_r != OP_UPDATE)) ? best_nxt : '0;
            out_count_nxt  = count_r;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Per-cell controls; only the cell at the back position loads on push back.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctrl[i].load = push_back_en && (count_r[IDX_W-1:0] == IDX_W'(i));
      ctrl[i].shl  = shl_en;
      ctrl[i].shr  = shr_en;
    end
  end

  // The row of cells, linked to their neighbors.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    record_t next_src;
    record_t prev_src;

    if (g == DEPTH - 1) begin : g_back
      assign next_src = wrap_rec;
    end else begin : g_mid_n
      assign next_src = cell_q[g+1];
    end

    if (g == 0) begin : g_front
      assign prev_src = item_rec;
    end else begin : g_mid_p
      assign prev_src = cell_q[g-1];
    end

    krd_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl[g]),
      .next_rec (next_src),
      .prev_rec (prev_src),
      .load_rec (item_rec),
      .rec_q    (cell_q[g])
    );
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Scan and result payload registers.
  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    scan_op_r    <= scan_op_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    found_r      <= found_nxt;
    best_r       <= best_nxt;
    out_status_r <= out_status_nxt;
    out_rec_r    <= out_rec_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {3'b000, ENTRY_W'(out_count_r), out_rec_r.value, out_rec_r.key};

endmodule

`default_nettype wire

[test/tb_top.sv]
`default_nettype none

module tb_top;
  import krd_pkg::*;

  // The opcode that the block treats as a no-op.
  localparam logic [OP_W-1:0] OP_NOP = 3'd7;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 190;

  typedef struct packed {
    logic [ST_W-1:0]    status;
    logic [KEY_W-1:0]   fkey;
    logic [VAL_W-1:0]   fval;
    logic [ENTRY_W-1:0] count;
  } deque_result_t;

  // Tracks the deque contents and matches every result against the oldest
  // outstanding transaction.
  class deque_scoreboard;
    logic [KEY_W-1:0] key_ring[DEPTH];
    logic [VAL_W-1:0] val_ring[DEPTH];
    int               front_idx;
    int               held;
    deque_result_t    pending[$];
    int               errors;
    int               items;
    int               results;
    int               full_drops;
    int               misses;

    function new();
      front_idx  = 0;
      held       = 0;
      errors     = 0;
      items      = 0;
      results    = 0;
      full_drops = 0;
      misses     = 0;
    endfunction

    // Apply one accepted operation and queue the result it should produce.
    function void note_item(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                            logic [VAL_W-1:0] val);
      deque_result_t           r;
      int                      s;
      int                      slot;
      logic signed [VAL_W-1:0] best;
      r = '0;
      r.status = ST_OK;
      s = -1;
      case (op)
        OP_PUSH_BACK, OP_PUSH_FRONT: begin
          if (held >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            if (op == OP_PUSH_BACK) begin
              s = (front_idx + held) % DEPTH;
            end else begin
              front_idx = (front_idx + DEPTH - 1) % DEPTH;
              s = front_idx;
            end
            key_ring[s] = key;
            val_ring[s] = val;
            held++;
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          if (held == 0) begin
            r.status = ST_MISS;
          end else begin
            if (op == OP_POP_FRONT) front_idx = (front_idx + 1) % DEPTH;
            held--;
          end
        end
        OP_SEARCH, OP_UPDATE: begin
          // First record from the front whose key matches.
          for (int i = 0; i < held; i++) begin
            slot = (front_idx + i) % DEPTH;
            if (s < 0 && key_ring[slot] == key) s = slot;
          end
          if (s < 0) begin
            r.status = ST_MISS;
          end else if (op == OP_SEARCH) begin
            r.fkey = key_ring[s];
            r.fval = val_ring[s];
          end else begin
            val_ring[s] = val;
          end
        end
        OP_MAX: begin
          // The maximum starts at zero, so all-negative contents find nothing.
          best = '0;
          for (int i = 0; i < held; i++) begin
            slot = (front_idx + i) % DEPTH;
            if ($signed(val_ring[slot]) > best) best = val_ring[slot];
          end
          for (int i = 0; i < held; i++) begin
            slot = (front_idx + i) % DEPTH;
            if (s < 0 && val_ring[slot] == best) s = slot;
          end
          if (s < 0) begin
            r.status = ST_MISS;
          end else begin
            r.fkey = key_ring[s];
            r.fval = val_ring[s];
          end
        end
        default: begin
        end
      endcase
      r.count = held[ENTRY_W-1:0];
      if (r.status == ST_FULL) full_drops++;
      if (r.status == ST_MISS) misses++;
      items++;
      pending.push_back(r);
    endfunction

    // Compare one result transaction with the oldest expectation.
    function void check_result(deque_result_t got);
      deque_result_t want;
      results++;
      if (pending.size() == 0) begin
        if (errors < 10) $display("ERROR: result with no transaction pending");
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.fkey !== want.fkey ||
          got.fval !== want.fval || got.count !== want.count) begin
        if (errors < 10) begin
          $display("ERROR: result %0d: status %0d key %h value %h count %0d",
                   results, got.status, got.fkey, got.fval, got.count);
          $display("       expected: status %0d key %h value %h count %0d",
                   want.status, want.fkey, want.fval, want.count);
        end
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [63:0]         in_tdata;
  logic [OP_W-1:0]     in_tuser;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [71:0]         out_tdata;
  logic [ST_W-1:0]     out_tuser;

  deque_scoreboard sb = new();
  int idle_pct  = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  keyed_record_deque_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // The clock starts low so that the first rising edge falls at time 5.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result side: check accepted results, stall at random, and watch for hangs.
  always @(posedge clk) begin
    deque_result_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.status = out_tuser;
        got.fkey   = out_tdata[31:0];
        got.fval   = out_tdata[63:32];
        got.count  = out_tdata[68:64];
        sb.check_result(got);
      end
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    out_tready <= ($urandom_range(99) >= stall_pct);
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offer one item, after a random gap, and hold it until it is taken.
  task automatic send_item(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                           logic [VAL_W-1:0] val);
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {val, key};
    in_tuser  <= op;
    @(posedge clk);
    while (!(in_tvalid && in_tready)) @(posedge clk);
    sb.note_item(op, key, val);
  endtask

  initial begin
    logic [KEY_W-1:0] key_pool[6];
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
    bit               filling;
    int               r;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty queue, sign extremes, ties, duplicates and misses.
    send_item(OP_POP_FRONT, 32'h0, 32'h0);
    send_item(OP_POP_BACK, 32'h0, 32'h0);
    send_item(OP_SEARCH, 32'h8000_0000, 32'h0);
    send_item(OP_UPDATE, 32'h0, 32'h1);
    send_item(OP_MAX, 32'h0, 32'h0);
    send_item(OP_NOP, 32'hffff_ffff, 32'hffff_ffff);
    send_item(OP_PUSH_BACK, 32'h7fff_ffff, 32'h8000_0000);
    send_item(OP_PUSH_FRONT, 32'h8000_0000, 32'hffff_ffff);
    send_item(OP_MAX, 32'h0, 32'h0);
    send_item(OP_SEARCH, 32'h8000_0000, 32'h0);
    send_item(OP_PUSH_BACK, 32'h0, 32'h0);
    send_item(OP_MAX, 32'h0, 32'h0);
    send_item(OP_PUSH_FRONT, 32'hffff_ffff, 32'h5);
    send_item(OP_PUSH_BACK, 32'h1234, 32'h7fff_ffff);
    send_item(OP_PUSH_BACK, 32'hffff_ffff, 32'h6);
    send_item(OP_SEARCH, 32'hffff_ffff, 32'h0);
    send_item(OP_MAX, 32'h0, 32'h0);
    send_item(OP_UPDATE, 32'hffff_ffff, 32'h7fff_ffff);
    send_item(OP_MAX, 32'h0, 32'h0);
    send_item(OP_UPDATE, 32'h5555_5555, 32'h1);
    send_item(OP_SEARCH, 32'h5555_5555, 32'h0);
    send_item(OP_POP_BACK, 32'h0, 32'h0);
    send_item(OP_POP_FRONT, 32'h0, 32'h0);
    send_item(OP_NOP, 32'h0, 32'h0);

    // Random: swing between filling up and draining so that both the full
    // and the empty queue are reached often; keys mostly come from a small
    // pool so that searches and updates hit.
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0;
    for (int i = 3; i < 6; i++) key_pool[i] = $urandom;
    filling = 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 64; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 64; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (sb.held == DEPTH && $urandom_range(3) == 0) filling = 1'b0;
        if (sb.held == 0 && $urandom_range(3) == 0) filling = 1'b1;
        if ($urandom_range(19) == 0) key_pool[$urandom_range(5)] = $urandom;
        r = $urandom_range(99);
        if (filling) begin
          if (r < 35)      op = OP_PUSH_BACK;
          else if (r < 60) op = OP_PUSH_FRONT;
          else if (r < 68) op = OP_POP_FRONT;
          else if (r < 75) op = OP_POP_BACK;
          else if (r < 84) op = OP_SEARCH;
          else if (r < 92) op = OP_UPDATE;
          else if (r < 99) op = OP_MAX;
          else             op = OP_NOP;
        end else begin
          if (r < 10)      op = OP_PUSH_BACK;
          else if (r < 20) op = OP_PUSH_FRONT;
          else if (r < 45) op = OP_POP_FRONT;
          else if (r < 70) op = OP_POP_BACK;
          else if (r < 80) op = OP_SEARCH;
          else if (r < 90) op = OP_UPDATE;
          else if (r < 99) op = OP_MAX;
          else             op = OP_NOP;
        end
        key = ($urandom_range(3) != 0) ? key_pool[$urandom_range(5)] : $urandom;
        case ($urandom_range(5))
          0: val = 32'h7fff_ffff;
          1: val = 32'h8000_0000;
          2: val = $urandom_range(8) - 4;
          3: val = -$urandom_range(1000);
          default: val = $urandom;
        endcase
        send_item(op, key, val);
      end
    end
    in_tvalid <= 1'b0;

    // Drain the outstanding results, then allow one full scan for strays.
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    if (sb.pending.size() != 0) sb.errors++;

    $display("Ran %0d operations through idle/stall phases; %0d results checked.",
             sb.items, sb.results);
    $display("Saw %0d dropped pushes on a full queue and %0d empty/not-found results.",
             sb.full_drops, sb.misses);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches in total", sb.errors);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
